// ===== rtl/pai_pkg.sv =====
// Shared constants, types and codes of the position history interpolator.
`timescale 1ns / 1ps
package pai_pkg;

   localparam int HistDepth       = 16;
   localparam int PtrW            = $clog2(HistDepth);
   localparam int CntW            = $clog2(HistDepth + 1);
   localparam int DataW           = 32;
   localparam int CsrIdxW         = 2;
   localparam int CsrDataW        = 31;
   localparam int TolW            = 16;
   localparam int SrcW            = 3;
   localparam int FracBitsDefault = 16;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_RETENTION = 2'd0,
      CSR_SPACING   = 2'd1,
      CSR_TOLERANCE = 2'd2
   } csr_index_type;

   typedef enum logic [SrcW-1:0] {
      SRC_TICK   = 3'd0,
      SRC_INTERP = 3'd1,
      SRC_BACK   = 3'd2,
      SRC_FWD    = 3'd3,
      SRC_SINGLE = 3'd4,
      SRC_LIVE   = 3'd5,
      SRC_ZERO   = 3'd6
   } src_type;

   typedef struct packed {
      logic signed [DataW-1:0] tm;
      logic signed [DataW-1:0] x;
      logic signed [DataW-1:0] y;
      logic signed [DataW-1:0] z;
   } entry_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_START, ST_NEWCHK, ST_OLD, ST_OLDCHK, ST_DECIDE, ST_ONE,
      ST_W0, ST_WCHK, ST_BK1, ST_BK2, ST_MATH, ST_MWAIT, ST_FIN
   } ctrl_state_type;

   typedef enum logic [2:0] {
      LN_IDLE, LN_MUL_LO, LN_MUL_HI, LN_ADD, LN_DIV_INIT, LN_DIV, LN_FIN
   } lin_state_type;

   typedef struct packed {
      logic            item_ld;
      logic            rd_en;
      logic [PtrW-1:0] rd_addr;
      logic            wr_en;
      logic [PtrW-1:0] wr_addr;
      logic            newest_ld;
      logic            prev_ld;
      logic            first_ld;
      logic            a_ld_prev;
      logic            a_ld_rd;
      logic            b_ld_prev;
      logic            b_ld_rd;
      logic            lin_start;
      logic [1:0]      axis;
      logic            res_clr;
      logic            res_live;
      logic            res_rd;
      logic            out_ld;
      src_type         src;
      logic            retired;
      logic [CntW-1:0] count;
   } cmd_type;

   typedef struct packed {
      logic is_query;
      logic item_valid;
      logic rd_later_t;
      logic rd_too_old;
      logic space_ok;
      logic in_iv;
      logic t_lt_first;
      logic t_gt_rd;
      logic lin_done;
      logic out_free;
   } status_type;

endpackage

// ===== rtl/pai_req_if.sv =====
// Input channel: one tick or query word.
`timescale 1ns / 1ps
interface pai_req_if;
   logic        valid;
   logic        ready;
   logic        command;
   logic [31:0] time_value;
   logic [31:0] pos_x;
   logic [31:0] pos_y;
   logic [31:0] pos_z;
   logic        object_valid;

   modport source (output valid, command, time_value, pos_x, pos_y, pos_z, object_valid,
                   input ready);
   modport sink   (input valid, command, time_value, pos_x, pos_y, pos_z, object_valid,
                   output ready);
endinterface

// ===== rtl/pai_rsp_if.sv =====
// Result channel: one answer word per input word.
`timescale 1ns / 1ps
interface pai_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] out_x;
   logic [31:0] out_y;
   logic [31:0] out_z;
   logic [2:0]  answer_source;
   logic        retired;
   logic [4:0]  entry_count;

   modport source (output valid, out_x, out_y, out_z, answer_source, retired, entry_count,
                   input ready);
   modport sink   (input valid, out_x, out_y, out_z, answer_source, retired, entry_count,
                   output ready);
endinterface

// ===== rtl/position_history_interpolator.sv =====
// Top level of the position history interpolator.
//
//   channel  | dir | handshake          | word
//   req_ch   | in  | valid/ready        | command, time_value, pos_x/y/z, object_valid
//   rsp_ch   | out | valid/ready        | out_x/y/z, answer_source, retired, entry_count
//   csr_*    | in  | csr_we, no wait    | csr_index, csr_wdata
//
// One word at a time; the history is one memory with a registered read port.
// Query: an interval walk over the entries, then, for an interpolated or extrapolated
// answer, three passes of the shared multiply/divide unit (34 divide steps).
// Reset is synchronous; the history is empty after it. A stalled result is held
// in the output register while the next word is taken.
`timescale 1ns / 1ps
module position_history_interpolator import pai_pkg::*; #(
   parameter int FRAC_BITS = FracBitsDefault
) (
   input  logic                clock,
   input  logic                reset,
   pai_req_if.sink             req_ch,
   pai_rsp_if.source           rsp_ch,
   input  logic                csr_we,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_wdata
);

   cmd_type    cmd;
   status_type st;

   logic                    lin_start, lin_done;
   logic signed [DataW-1:0] lin_p0, lin_result;
   logic signed [DataW:0]   lin_dp, lin_dt, lin_dur;

   pai_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .st        (st),
      .cmd       (cmd)
   );

   pai_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_command       (req_ch.command),
      .req_time_value    (req_ch.time_value),
      .req_pos_x         (req_ch.pos_x),
      .req_pos_y         (req_ch.pos_y),
      .req_pos_z         (req_ch.pos_z),
      .req_object_valid  (req_ch.object_valid),
      .rsp_ready         (rsp_ch.ready),
      .rsp_valid         (rsp_ch.valid),
      .rsp_out_x         (rsp_ch.out_x),
      .rsp_out_y         (rsp_ch.out_y),
      .rsp_out_z         (rsp_ch.out_z),
      .rsp_answer_source (rsp_ch.answer_source),
      .rsp_retired       (rsp_ch.retired),
      .rsp_entry_count   (rsp_ch.entry_count),
      .lin_start         (lin_start),
      .lin_p0            (lin_p0),
      .lin_dp            (lin_dp),
      .lin_dt            (lin_dt),
      .lin_dur           (lin_dur),
      .lin_done          (lin_done),
      .lin_result        (lin_result),
      .cmd               (cmd),
      .st                (st)
   );

   pai_lin u_lin (
      .clock  (clock),
      .reset  (reset),
      .start  (lin_start),
      .p0     (lin_p0),
      .dp     (lin_dp),
      .dt     (lin_dt),
      .dur    (lin_dur),
      .done   (lin_done),
      .result (lin_result)
   );

endmodule

// ===== rtl/pai_lin.sv =====
// Iterative linear step unit: p0 + dp*dt/dur, truncated quotient, saturated sum.
`timescale 1ns / 1ps
module pai_lin import pai_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [DataW-1:0] p0,
   input  logic signed [DataW:0]   dp,
   input  logic signed [DataW:0]   dt,
   input  logic signed [DataW:0]   dur,
   output logic                    done,
   output logic signed [DataW-1:0] result
);

   localparam int DivSteps = 34;

   lin_state_type state_ff, state_in;
   logic signed [DataW-1:0] p0_ff, p0_in;
   logic [32:0] mdp_ff, mdp_in, mdt_ff, mdt_in, mdur_ff, mdur_in;
   logic        neg_ff, neg_in, ovf_ff, ovf_in;
   logic [65:0] acc_ff, acc_in;
   logic [48:0] prod_ff, prod_in;
   logic [32:0] rem_ff, rem_in;
   logic [33:0] quo_ff, quo_in;
   logic [5:0]  cnt_ff, cnt_in;

   logic [49:0] plo;
   logic [48:0] phi;
   logic [33:0] r2, diff;
   logic        ge;
   logic signed [35:0] sum;

   function automatic logic [32:0] mag33(input logic signed [32:0] v);
      return v[32] ? 33'(-v) : 33'(v);
   endfunction

   assign plo  = mdp_ff * mdt_ff[16:0];
   assign phi  = mdp_ff * mdt_ff[32:17];
   assign r2   = {rem_ff, quo_ff[33]};
   assign diff = r2 - {1'b0, mdur_ff};
   assign ge   = (r2 >= {1'b0, mdur_ff});
   assign sum  = neg_ff ? (36'(p0_ff) - $signed({2'b00, quo_ff}))
                        : (36'(p0_ff) + $signed({2'b00, quo_ff}));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LN_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      p0_ff   <= p0_in;
      mdp_ff  <= mdp_in;
      mdt_ff  <= mdt_in;
      mdur_ff <= mdur_in;
      neg_ff  <= neg_in;
      ovf_ff  <= ovf_in;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      cnt_ff  <= cnt_in;
   end

   always_comb begin
      state_in = state_ff;
      p0_in    = p0_ff;
      mdp_in   = mdp_ff;
      mdt_in   = mdt_ff;
      mdur_in  = mdur_ff;
      neg_in   = neg_ff;
      ovf_in   = ovf_ff;
      acc_in   = acc_ff;
      prod_in  = prod_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      cnt_in   = cnt_ff;
      done     = 1'b0;
      result   = '0;
      unique case (state_ff)
         LN_IDLE: begin
            if (start) begin
               p0_in    = p0;
               mdp_in   = mag33(dp);
               mdt_in   = mag33(dt);
               mdur_in  = mag33(dur);
               neg_in   = dp[32] ^ dt[32] ^ dur[32];
               state_in = LN_MUL_LO;
            end
         end
         LN_MUL_LO: begin
            acc_in   = 66'(plo);
            state_in = LN_MUL_HI;
         end
         LN_MUL_HI: begin
            prod_in  = phi;
            state_in = LN_ADD;
         end
         LN_ADD: begin
            acc_in   = acc_ff + {prod_ff, 17'b0};
            state_in = LN_DIV_INIT;
         end
         LN_DIV_INIT: begin
            ovf_in = 1'b0;
            quo_in = '0;
            if (mdur_ff == '0) begin
               state_in = LN_FIN;
            end else if ({1'b0, acc_ff[65:34]} >= mdur_ff) begin
               ovf_in   = 1'b1;
               state_in = LN_FIN;
            end else begin
               rem_in   = {1'b0, acc_ff[65:34]};
               quo_in   = acc_ff[33:0];
               cnt_in   = '0;
               state_in = LN_DIV;
            end
         end
         LN_DIV: begin
            rem_in = ge ? diff[32:0] : r2[32:0];
            quo_in = {quo_ff[32:0], ge};
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(DivSteps - 1)) begin
               state_in = LN_FIN;
            end
         end
         LN_FIN: begin
            done = 1'b1;
            if (ovf_ff) begin
               result = neg_ff ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            end else if (sum > 36'sh0_7FFF_FFFF) begin
               result = 32'sh7FFF_FFFF;
            end else if (sum < -36'sh0_8000_0000) begin
               result = 32'sh8000_0000;
            end else begin
               result = sum[31:0];
            end
            state_in = LN_IDLE;
         end
         default: state_in = LN_IDLE;
      endcase
   end

endmodule

// ===== rtl/pai_dp.sv =====
// Datapath: configuration, history memory, entry registers, compares and result word.
`timescale 1ns / 1ps
module pai_dp import pai_pkg::*; #(
   parameter int FRAC_BITS = FracBitsDefault
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_wdata,
   input  logic                req_command,
   input  logic [DataW-1:0]    req_time_value,
   input  logic [DataW-1:0]    req_pos_x,
   input  logic [DataW-1:0]    req_pos_y,
   input  logic [DataW-1:0]    req_pos_z,
   input  logic                req_object_valid,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output logic [DataW-1:0]    rsp_out_x,
   output logic [DataW-1:0]    rsp_out_y,
   output logic [DataW-1:0]    rsp_out_z,
   output logic [SrcW-1:0]     rsp_answer_source,
   output logic                rsp_retired,
   output logic [CntW-1:0]     rsp_entry_count,
   output logic                lin_start,
   output logic signed [DataW-1:0] lin_p0,
   output logic signed [DataW:0]   lin_dp,
   output logic signed [DataW:0]   lin_dt,
   output logic signed [DataW:0]   lin_dur,
   input  logic                lin_done,
   input  logic signed [DataW-1:0] lin_result,
   input  cmd_type             cmd,
   output status_type          st
);

   localparam longint One      = 64'sd1 <<< FRAC_BITS;
   localparam longint RetReset = 3 * One;
   localparam longint SpcReset = (3 * One + 5) / 10;
   localparam longint TolReset = (One + 5000) / 10000;

   logic [CsrDataW-1:0] ret_ff, spc_ff;
   logic [TolW-1:0]     tol_ff;

   logic                    query_ff, vld_ff;
   logic signed [DataW-1:0] t_ff, px_ff, py_ff, pz_ff;

   entry_type mem [HistDepth];
   entry_type rd_ff, prev_ff, a_ff, b_ff;
   logic signed [DataW-1:0] newest_ff, first_ff;
   logic signed [DataW-1:0] res_x_ff, res_y_ff, res_z_ff;

   logic                    valid_ff;
   logic [DataW-1:0]        ox_ff, oy_ff, oz_ff;
   logic [SrcW-1:0]         osrc_ff;
   logic                    oret_ff;
   logic [CntW-1:0]         ocnt_ff;

   logic signed [33:0] t34, rd34, lo34, hi34, tol34;
   logic signed [DataW-1:0] pa, pb;

   always_ff @(posedge clock) begin
      if (reset) begin
         ret_ff <= CsrDataW'(RetReset);
         spc_ff <= CsrDataW'(SpcReset);
         tol_ff <= TolW'(TolReset);
      end else if (csr_we) begin
         if (csr_index == CSR_RETENTION) ret_ff <= csr_wdata;
         if (csr_index == CSR_SPACING)   spc_ff <= csr_wdata;
         if (csr_index == CSR_TOLERANCE) tol_ff <= csr_wdata[TolW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.item_ld) begin
         query_ff <= req_command;
         t_ff     <= req_time_value;
         px_ff    <= req_pos_x;
         py_ff    <= req_pos_y;
         pz_ff    <= req_pos_z;
         vld_ff   <= req_object_valid;
      end
      if (cmd.wr_en) mem[cmd.wr_addr] <= '{tm: t_ff, x: px_ff, y: py_ff, z: pz_ff};
      if (cmd.rd_en) rd_ff <= mem[cmd.rd_addr];
      if (cmd.newest_ld) newest_ff <= rd_ff.tm;
      if (cmd.first_ld) first_ff <= rd_ff.tm;
      if (cmd.prev_ld) prev_ff <= rd_ff;
      if (cmd.a_ld_prev) a_ff <= prev_ff;
      if (cmd.a_ld_rd) a_ff <= rd_ff;
      if (cmd.b_ld_prev) b_ff <= prev_ff;
      if (cmd.b_ld_rd) b_ff <= rd_ff;
      if (cmd.res_clr) begin
         res_x_ff <= '0;
         res_y_ff <= '0;
         res_z_ff <= '0;
      end
      if (cmd.res_live) begin
         res_x_ff <= px_ff;
         res_y_ff <= py_ff;
         res_z_ff <= pz_ff;
      end
      if (cmd.res_rd) begin
         res_x_ff <= rd_ff.x;
         res_y_ff <= rd_ff.y;
         res_z_ff <= rd_ff.z;
      end
      if (lin_done) begin
         unique case (cmd.axis)
            2'd0:    res_x_ff <= lin_result;
            2'd1:    res_y_ff <= lin_result;
            default: res_z_ff <= lin_result;
         endcase
      end
   end

   assign t34   = 34'(t_ff);
   assign rd34  = 34'(rd_ff.tm);
   assign lo34  = (prev_ff.tm < rd_ff.tm) ? 34'(prev_ff.tm) : rd34;
   assign hi34  = (prev_ff.tm < rd_ff.tm) ? rd34 : 34'(prev_ff.tm);
   assign tol34 = $signed({18'b0, tol_ff});

   assign st.is_query   = query_ff;
   assign st.item_valid = vld_ff;
   assign st.rd_later_t = rd_ff.tm > t_ff;
   assign st.rd_too_old = rd34 < (t34 - $signed({3'b000, ret_ff}));
   assign st.space_ok   = t34 > (34'(newest_ff) + $signed({3'b000, spc_ff}));
   assign st.in_iv      = (t34 >= lo34 - tol34) && (t34 <= hi34 + tol34);
   assign st.t_lt_first = t_ff < first_ff;
   assign st.t_gt_rd    = t_ff > rd_ff.tm;
   assign st.lin_done   = lin_done;
   assign st.out_free   = !valid_ff || rsp_ready;

   always_comb begin
      unique case (cmd.axis)
         2'd0: begin
            pa = a_ff.x;
            pb = b_ff.x;
         end
         2'd1: begin
            pa = a_ff.y;
            pb = b_ff.y;
         end
         default: begin
            pa = a_ff.z;
            pb = b_ff.z;
         end
      endcase
   end

   assign lin_start = cmd.lin_start;
   assign lin_p0    = pa;
   assign lin_dp    = 33'(pb) - 33'(pa);
   assign lin_dt    = 33'(t_ff) - 33'(a_ff.tm);
   assign lin_dur   = 33'(b_ff.tm) - 33'(a_ff.tm);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.out_ld) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_ld) begin
         ox_ff   <= res_x_ff;
         oy_ff   <= res_y_ff;
         oz_ff   <= res_z_ff;
         osrc_ff <= cmd.src;
         oret_ff <= cmd.retired;
         ocnt_ff <= cmd.count;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_out_x         = ox_ff;
   assign rsp_out_y         = oy_ff;
   assign rsp_out_z         = oz_ff;
   assign rsp_answer_source = osrc_ff;
   assign rsp_retired       = oret_ff;
   assign rsp_entry_count   = ocnt_ff;

endmodule

// ===== rtl/pai_ctrl.sv =====
// Controller: history ring pointers, retired flag and the item sequence.
`timescale 1ns / 1ps
module pai_ctrl import pai_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type st,
   output cmd_type    cmd
);

   ctrl_state_type  state_ff, state_in;
   logic [CntW-1:0] count_ff, count_in;
   logic [PtrW-1:0] oldest_ff, oldest_in;
   logic [PtrW-1:0] idx_ff, idx_in;
   logic [1:0]      axis_ff, axis_in;
   logic            retired_ff, retired_in;
   src_type         src_ff, src_in;
   logic [CntW-1:0] last;

   assign last = count_ff - CntW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         oldest_ff  <= '0;
         idx_ff     <= '0;
         axis_ff    <= '0;
         retired_ff <= 1'b0;
         src_ff     <= SRC_TICK;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         oldest_ff  <= oldest_in;
         idx_ff     <= idx_in;
         axis_ff    <= axis_in;
         retired_ff <= retired_in;
         src_ff     <= src_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      oldest_in   = oldest_ff;
      idx_in      = idx_ff;
      axis_in     = axis_ff;
      retired_in  = retired_ff;
      src_in      = src_ff;
      cmd         = '0;
      cmd.axis    = axis_ff;
      cmd.src     = src_ff;
      cmd.retired = retired_ff;
      cmd.count   = count_ff;
      req_ready   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.item_ld = req_valid;
            if (req_valid) state_in = ST_START;
         end
         ST_START: begin
            if (!st.is_query) begin
               if (count_ff == '0) begin
                  state_in = ST_DECIDE;
               end else begin
                  cmd.rd_en   = 1'b1;
                  cmd.rd_addr = oldest_ff + last[PtrW-1:0];
                  state_in    = ST_NEWCHK;
               end
            end else if (count_ff == '0) begin
               cmd.res_live = st.item_valid;
               cmd.res_clr  = !st.item_valid;
               src_in       = st.item_valid ? SRC_LIVE : SRC_ZERO;
               state_in     = ST_FIN;
            end else begin
               cmd.rd_en   = 1'b1;
               cmd.rd_addr = oldest_ff;
               state_in    = (count_ff == CntW'(1)) ? ST_ONE : ST_W0;
            end
         end
         ST_NEWCHK: begin
            cmd.newest_ld = 1'b1;
            if (st.rd_later_t) begin
               count_in = '0;
               state_in = ST_DECIDE;
            end else begin
               state_in = ST_OLD;
            end
         end
         ST_OLD: begin
            if (count_ff == '0) begin
               state_in = ST_DECIDE;
            end else begin
               cmd.rd_en   = 1'b1;
               cmd.rd_addr = oldest_ff;
               state_in    = ST_OLDCHK;
            end
         end
         ST_OLDCHK: begin
            if (st.rd_too_old) begin
               oldest_in = oldest_ff + PtrW'(1);
               count_in  = last;
               state_in  = ST_OLD;
            end else begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            cmd.res_clr = 1'b1;
            src_in      = SRC_TICK;
            if (count_ff == '0 || st.space_ok) begin
               if (st.item_valid) begin
                  cmd.wr_en   = 1'b1;
                  cmd.wr_addr = oldest_ff + count_ff[PtrW-1:0];
                  if (count_ff == CntW'(HistDepth)) begin
                     oldest_in = oldest_ff + PtrW'(1);
                  end else begin
                     count_in = count_ff + CntW'(1);
                  end
               end else begin
                  retired_in = 1'b1;
               end
            end
            state_in = ST_FIN;
         end
         ST_ONE: begin
            cmd.res_rd = 1'b1;
            src_in     = SRC_SINGLE;
            state_in   = ST_FIN;
         end
         ST_W0: begin
            cmd.prev_ld  = 1'b1;
            cmd.first_ld = 1'b1;
            idx_in       = PtrW'(1);
            cmd.rd_en    = 1'b1;
            cmd.rd_addr  = oldest_ff + PtrW'(1);
            state_in     = ST_WCHK;
         end
         ST_WCHK: begin
            if (st.in_iv) begin
               cmd.a_ld_prev = 1'b1;
               cmd.b_ld_rd   = 1'b1;
               src_in        = SRC_INTERP;
               state_in      = ST_MATH;
            end else if ({1'b0, idx_ff} == last) begin
               if (st.t_lt_first) begin
                  cmd.rd_en   = 1'b1;
                  cmd.rd_addr = oldest_ff;
                  src_in      = SRC_BACK;
                  state_in    = ST_BK1;
               end else if (st.t_gt_rd) begin
                  cmd.a_ld_rd   = 1'b1;
                  cmd.b_ld_prev = 1'b1;
                  src_in        = SRC_FWD;
                  state_in      = ST_MATH;
               end else begin
                  cmd.res_clr = 1'b1;
                  src_in      = SRC_ZERO;
                  state_in    = ST_FIN;
               end
            end else begin
               cmd.prev_ld = 1'b1;
               idx_in      = idx_ff + PtrW'(1);
               cmd.rd_en   = 1'b1;
               cmd.rd_addr = oldest_ff + idx_ff + PtrW'(1);
            end
         end
         ST_BK1: begin
            cmd.a_ld_rd = 1'b1;
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = oldest_ff + PtrW'(1);
            state_in    = ST_BK2;
         end
         ST_BK2: begin
            cmd.b_ld_rd = 1'b1;
            state_in    = ST_MATH;
         end
         ST_MATH: begin
            cmd.lin_start = 1'b1;
            state_in      = ST_MWAIT;
         end
         ST_MWAIT: begin
            if (st.lin_done) begin
               if (axis_ff == 2'd2) begin
                  axis_in  = '0;
                  state_in = ST_FIN;
               end else begin
                  axis_in  = axis_ff + 2'd1;
                  state_in = ST_MATH;
               end
            end
         end
         ST_FIN: begin
            if (st.out_free) begin
               cmd.out_ld = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// ===== rtl/pai_checker.sv =====
// Port checker for the position history interpolator, bound to the top level.
`timescale 1ns / 1ps
module pai_checker import pai_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [DataW-1:0] out_x,
   input logic [DataW-1:0] out_y,
   input logic [DataW-1:0] out_z,
   input logic [SrcW-1:0]  answer_source,
   input logic             retired,
   input logic [CntW-1:0]  entry_count
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_x) && $stable(answer_source)
         && $stable(entry_count))
      else $error("result word changed while stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken while a word is in work");

   a_tick_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && answer_source == SRC_TICK |-> out_x == '0 && out_y == '0 && out_z == '0)
      else $error("tick answer carries a position");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> entry_count <= CntW'(HistDepth) && answer_source != SrcW'(7))
      else $error("entry count or answer source out of range");

   a_retired_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(rsp_valid && retired) |-> retired)
      else $error("retired flag dropped");

endmodule

bind position_history_interpolator pai_checker u_pai_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .out_x         (rsp_ch.out_x),
   .out_y         (rsp_ch.out_y),
   .out_z         (rsp_ch.out_z),
   .answer_source (rsp_ch.answer_source),
   .retired       (rsp_ch.retired),
   .entry_count   (rsp_ch.entry_count)
);

// ===== bench/pai_checker.sv =====
// Checker for the position history interpolator: watches both channels, predicts and compares.
`timescale 1ns / 1ps
module pai_scoreboard import pai_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   pai_req_if                req_ch,
   pai_rsp_if                rsp_ch,
   input  logic              csr_we,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_wdata,
   output int                fail_count,
   output int                pending
);
   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      src_type            src;
      logic               retired;
      logic [4:0]         count;
   } answer_type;

   entry_type   hist [HistDepth];
   logic [3:0]  head;
   int          held;
   logic        retired_q;
   longint      keep_age;
   longint      gap;
   longint      tol;
   answer_type  answers [$];

   assign pending = answers.size();

   function automatic longint newest_time();
      return longint'(hist[(head + held - 1) % HistDepth].tm);
   endfunction

   function automatic logic signed [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic logic signed [31:0] lerp(longint p0, longint dp, longint dt,
                                               longint dur);
      logic           neg;
      logic [127:0]   prod;
      logic [127:0]   q;
      longint         qv;
      if (dur == 0) return clamp32(p0);
      neg  = ((dp < 0) != (dt < 0)) != (dur < 0);
      prod = 128'(dp < 0 ? -dp : dp) * 128'(dt < 0 ? -dt : dt);
      q    = prod / 128'(dur < 0 ? -dur : dur);
      if (q > (128'd1 << 40)) q = 128'd1 << 40;
      qv = longint'(q[63:0]);
      return clamp32(neg ? p0 - qv : p0 + qv);
   endfunction

   task automatic predict_answer(input logic cmd, input logic signed [31:0] tv,
                                 input logic signed [31:0] px, input logic signed [31:0] py,
                                 input logic signed [31:0] pz, input logic ov);
      answer_type r;
      longint     t, lo, hi, ta, tb;
      int         a, b, i;
      logic       found;
      entry_type  ea, eb;
      t = longint'(tv);
      r = '0;
      r.src = SRC_TICK;
      if (!cmd) begin
         if (held > 0 && newest_time() > t) held = 0;
         while (held > 0 && longint'(hist[head].tm) < t - keep_age) begin
            head = head + 1;
            held--;
         end
         if (held == 0 || t > newest_time() + gap) begin
            if (ov) begin
               if (held >= HistDepth) begin
                  head = head + 1;
                  held--;
               end
               hist[(head + held) % HistDepth] = '{tm: tv, x: px, y: py, z: pz};
               held++;
            end else begin
               retired_q = 1'b1;
            end
         end
      end else if (held == 0) begin
         if (ov) begin
            r.x = px; r.y = py; r.z = pz; r.src = SRC_LIVE;
         end else begin
            r.src = SRC_ZERO;
         end
      end else if (held == 1) begin
         r.x = hist[head].x; r.y = hist[head].y; r.z = hist[head].z;
         r.src = SRC_SINGLE;
      end else begin
         found = 1'b0;
         a = 0; b = 0;
         for (i = 1; i < held && !found; i++) begin
            a = (head + i - 1) % HistDepth;
            b = (head + i) % HistDepth;
            ta = longint'(hist[a].tm);
            tb = longint'(hist[b].tm);
            lo = ta < tb ? ta : tb;
            hi = ta < tb ? tb : ta;
            if (t >= lo - tol && t <= hi + tol) found = 1'b1;
         end
         if (found) begin
            r.src = SRC_INTERP;
         end else if (t < longint'(hist[head].tm)) begin
            a = head; b = (head + 1) % HistDepth; r.src = SRC_BACK;
         end else if (t > newest_time()) begin
            a = (head + held - 1) % HistDepth; b = (head + held - 2) % HistDepth;
            r.src = SRC_FWD;
         end else begin
            r.src = SRC_ZERO;
         end
         ea = hist[a];
         eb = hist[b];
         if (r.src == SRC_INTERP || r.src == SRC_BACK) begin
            r.x = lerp(ea.x, longint'(eb.x) - ea.x, t - ea.tm, longint'(eb.tm) - ea.tm);
            r.y = lerp(ea.y, longint'(eb.y) - ea.y, t - ea.tm, longint'(eb.tm) - ea.tm);
            r.z = lerp(ea.z, longint'(eb.z) - ea.z, t - ea.tm, longint'(eb.tm) - ea.tm);
         end else if (r.src == SRC_FWD) begin
            r.x = lerp(ea.x, longint'(ea.x) - eb.x, t - ea.tm, longint'(ea.tm) - eb.tm);
            r.y = lerp(ea.y, longint'(ea.y) - eb.y, t - ea.tm, longint'(ea.tm) - eb.tm);
            r.z = lerp(ea.z, longint'(ea.z) - eb.z, t - ea.tm, longint'(ea.tm) - eb.tm);
         end
      end
      r.retired = retired_q;
      r.count = 5'(held);
      answers = {answers, r};
   endtask

   always @(posedge clock) begin
      answer_type e;
      if (reset) begin
         head = 0;
         held = 0;
         retired_q = 1'b0;
         keep_age = 196608;
         gap = 19661;
         tol = 7;
         answers.delete();
         fail_count <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_RETENTION: keep_age = longint'(csr_wdata);
               CSR_SPACING:   gap = longint'(csr_wdata);
               CSR_TOLERANCE: tol = longint'(csr_wdata[TolW-1:0]);
               default: ;
            endcase
         end
         if (req_ch.valid && req_ch.ready)
            predict_answer(req_ch.command, req_ch.time_value, req_ch.pos_x, req_ch.pos_y,
                           req_ch.pos_z, req_ch.object_valid);
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (answers.size() == 0) begin
               $error("unexpected result word");
               fail_count <= fail_count + 1;
            end else begin
               e = answers.pop_front();
               if (rsp_ch.out_x !== e.x || rsp_ch.out_y !== e.y || rsp_ch.out_z !== e.z
                   || rsp_ch.answer_source !== e.src || rsp_ch.retired !== e.retired
                   || rsp_ch.entry_count !== e.count) begin
                  if (rsp_ch.out_x !== e.x)
                     $error("out_x expected %h got %h", e.x, rsp_ch.out_x);
                  if (rsp_ch.out_y !== e.y)
                     $error("out_y expected %h got %h", e.y, rsp_ch.out_y);
                  if (rsp_ch.out_z !== e.z)
                     $error("out_z expected %h got %h", e.z, rsp_ch.out_z);
                  if (rsp_ch.answer_source !== e.src)
                     $error("answer_source expected %0d got %0d", e.src,
                            rsp_ch.answer_source);
                  if (rsp_ch.retired !== e.retired)
                     $error("retired expected %b got %b", e.retired, rsp_ch.retired);
                  if (rsp_ch.entry_count !== e.count)
                     $error("entry_count expected %0d got %0d", e.count,
                            rsp_ch.entry_count);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

// ===== bench/tb_position_history_interpolator.sv =====
// Testbench top for the position history interpolator: stimulus, stalls and verdict.
`timescale 1ns / 1ps
module tb_position_history_interpolator;
   import pai_pkg::*;

   logic                clock;
   logic                reset;
   logic                csr_we;
   logic [CsrIdxW-1:0]  csr_index;
   logic [CsrDataW-1:0] csr_wdata;
   logic                stall_mode;
   int                  fail_count;
   int                  pending;
   int                  burst;
   int                  lfsr;
   logic [31:0]         sim_now;
   logic [31:0]         obj_x, obj_y, obj_z;

   pai_req_if req_ch ();
   pai_rsp_if rsp_ch ();

   position_history_interpolator u_top (
      .clock(clock), .reset(reset), .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   pai_scoreboard u_checker (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #200ms;
      $display("tb_position_history_interpolator: FAIL");
      $finish;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b1;
         lfsr <= 1;
      end else begin
         lfsr <= lfsr + 1;
         if (stall_mode) rsp_ch.ready <= ($urandom_range(0, 3) != 0);
         else rsp_ch.ready <= (lfsr % 7) != 3;
      end
   end

   task automatic send_word(input logic cmd, input logic [31:0] tv, input logic [31:0] px,
                            input logic [31:0] py, input logic [31:0] pz, input logic ov);
      int g;
      if (burst <= 0) begin
         g = $urandom_range(0, 3) == 0 ? $urandom_range(1, 60) : 0;
         if (g > 0) begin
            req_ch.valid <= 1'b0;
            repeat (g) @(posedge clock);
         end
         burst = $urandom_range(1, 12);
      end
      burst--;
      req_ch.valid <= 1'b1;
      req_ch.command <= cmd;
      req_ch.time_value <= tv;
      req_ch.pos_x <= px;
      req_ch.pos_y <= py;
      req_ch.pos_z <= pz;
      req_ch.object_valid <= ov;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      burst = 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [30:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic random_phase(input int n);
      logic [31:0] d;
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 19))
            0: send_word($urandom_range(0, 1), $urandom, $urandom, $urandom, $urandom,
                         $urandom_range(0, 1));
            1: begin
               sim_now = sim_now - $urandom_range(0, 200000);
               send_word(1'b0, sim_now, obj_x, obj_y, obj_z, 1'b1);
            end
            2, 3, 4, 5, 6, 7, 8, 9, 10: begin
               sim_now = sim_now + $urandom_range(0, 40000);
               d = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 300000);
               obj_x = obj_x + d - 150000;
               obj_y = obj_y - d;
               obj_z = $urandom_range(0, 7) == 0 ? $urandom : obj_z + 1000;
               send_word(1'b0, sim_now, obj_x, obj_y, obj_z, $urandom_range(0, 30) != 0);
            end
            default: send_word(1'b1, sim_now - $urandom_range(0, 400000) + 100000,
                               $urandom, $urandom, $urandom, $urandom_range(0, 1));
         endcase
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_RETENTION;
      csr_wdata = '0;
      stall_mode = 1'b0;
      burst = 0;
      sim_now = 0;
      obj_x = 0; obj_y = 0; obj_z = 0;
      req_ch.valid = 1'b0;
      req_ch.command = 1'b0;
      req_ch.time_value = '0;
      req_ch.pos_x = '0;
      req_ch.pos_y = '0;
      req_ch.pos_z = '0;
      req_ch.object_valid = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_word(1'b1, 32'h0, 32'h1234, 32'h5, 32'h6, 1'b1);
      send_word(1'b1, 32'h0, 32'h1234, 32'h5, 32'h6, 1'b0);
      send_word(1'b0, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'hffffffff, 1'b1);
      send_word(1'b1, 32'h7fffffff, 32'h0, 32'h0, 32'h0, 1'b0);
      send_word(1'b0, 32'h00000000, 32'h7fffffff, 32'h80000000, 32'h0, 1'b1);
      send_word(1'b0, 32'h00010000, 32'h80000000, 32'h7fffffff, 32'hffffffff, 1'b1);
      send_word(1'b1, 32'h7fffffff, 32'h0, 32'h0, 32'h0, 1'b1);
      send_word(1'b1, 32'h80000000, 32'h0, 32'h0, 32'h0, 1'b1);
      send_word(1'b1, 32'h00008000, 32'h0, 32'h0, 32'h0, 1'b1);
      send_word(1'b1, 32'h00010003, 32'h0, 32'h0, 32'h0, 1'b1);
      send_word(1'b0, 32'h7fffffff, 32'h1, 32'h2, 32'h3, 1'b1);
      send_word(1'b0, 32'h00020000, 32'h1, 32'h2, 32'h3, 1'b1);
      send_word(1'b0, 32'h00080000, 32'h1, 32'h2, 32'h3, 1'b0);
      for (int i = 0; i < 18; i++)
         send_word(1'b0, 32'h00090000 + i * 32'h8000, i * 32'h10000, -i, 32'h7fff0000,
                   1'b1);
      send_word(1'b1, 32'h00000000, 32'h0, 32'h0, 32'h0, 1'b1);
      drain();

      sim_now = 32'h00200000;
      stall_mode = 1'b1;
      random_phase(250);
      drain();

      write_reg(CSR_RETENTION, 31'h7fffffff);
      write_reg(CSR_SPACING, 31'd1);
      write_reg(CSR_TOLERANCE, 31'h0000ffff);
      random_phase(200);
      drain();

      write_reg(CSR_RETENTION, 31'd0);
      write_reg(CSR_SPACING, 31'h7fffffff);
      write_reg(CSR_TOLERANCE, 31'd0);
      random_phase(100);
      drain();

      stall_mode = 1'b0;
      write_reg(CSR_RETENTION, 31'd300000);
      write_reg(CSR_SPACING, 31'd5000);
      write_reg(CSR_TOLERANCE, 31'd100);
      random_phase(250);
      drain();

      if (fail_count == 0) $display("tb_position_history_interpolator: PASS");
      else $display("tb_position_history_interpolator: FAIL");
      $finish;
   end
endmodule

// ===== sim.f =====
rtl/pai_pkg.sv
rtl/pai_req_if.sv
rtl/pai_rsp_if.sv
rtl/pai_lin.sv
rtl/pai_dp.sv
rtl/pai_ctrl.sv
rtl/position_history_interpolator.sv
rtl/pai_checker.sv
bench/pai_checker.sv
bench/tb_position_history_interpolator.sv
